[hw/rtl/spi_hs_pkg.sv]
// spi_hs_pkg: shared types and constants of the SPI master with valid/ready header.
// Used by the front stage, the tick queue, the engine and the top level.
// No dependencies.
package spi_hs_pkg;

  localparam int unsigned SEND_W      = 32;
  localparam int unsigned RECV_W      = 32;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned FBITS_W     = 6;
  localparam int unsigned MFR_W       = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HALF_W-1:0]  HALF_RST      = 16'd10;
  localparam logic [FBITS_W-1:0] FBITS_RST     = 6'd32;
  localparam logic [MFR_W-1:0]   MFR_RST       = 10'd500;
  localparam logic [MFR_W-1:0]   FRAME_CNT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    MODE_RD = 2'd0,
    MODE_WR = 2'd1,
    MODE_RW = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF  = 2'd0,
    CFG_FBITS = 2'd1,
    CFG_MFR   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    mode_e             mode;
    logic              channel;
    logic [SEND_W-1:0] send_data;
    logic              miso_zero;
    logic              miso_one;
  } tick_t;

  typedef struct packed {
    logic              sck_zero;
    logic              mosi_zero;
    logic              cs_zero_n;
    logic              sck_one;
    logic              mosi_one;
    logic              cs_one_n;
    logic              busy_res;
    logic              done_res;
    logic              success;
    logic [RECV_W-1:0] recv_data;
    logic              last_valid;
    logic              last_ready;
  } res_t;

endpackage

[hw/rtl/spi_hs_front.sv]
// spi_hs_front: input stage; registers one tick beat and normalizes its mode.
// Depends on spi_hs_pkg.
module spi_hs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          start_req_i,
  input  logic [1:0]                    mode_i,
  input  logic                          channel_i,
  input  logic [spi_hs_pkg::SEND_W-1:0] send_data_i,
  input  logic                          miso_zero_i,
  input  logic                          miso_one_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output spi_hs_pkg::tick_t             push_o
);

  logic              vld_q;
  spi_hs_pkg::tick_t item_q;
  spi_hs_pkg::tick_t item_d;

  assign in_ready_o   = ~vld_q | push_ready_i;
  assign push_valid_o = vld_q;
  assign push_o       = item_q;

  always_comb begin
    item_d.start     = start_req_i;
    item_d.channel   = channel_i;
    item_d.send_data = send_data_i;
    item_d.miso_zero = miso_zero_i;
    item_d.miso_one  = miso_one_i;
    case (mode_i)
      spi_hs_pkg::MODE_WR: begin
        item_d.mode = spi_hs_pkg::MODE_WR;
      end
      spi_hs_pkg::MODE_RW: begin
        item_d.mode = spi_hs_pkg::MODE_RW;
      end
      default: begin
        item_d.mode = spi_hs_pkg::MODE_RD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      item_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q  <= 1'b1;
      item_q <= item_d;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

endmodule

[hw/rtl/spi_hs_queue.sv]
// spi_hs_queue: short FIFO of tick beats between the front stage and the engine.
// Depends on spi_hs_pkg.
module spi_hs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  spi_hs_pkg::tick_t push_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output spi_hs_pkg::tick_t pop_o
);

  localparam int unsigned QAW = (spi_hs_pkg::QUEUE_DEPTH > 1) ?
                                $clog2(spi_hs_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(spi_hs_pkg::QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] PTR_LAST = QAW'(spi_hs_pkg::QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] CNT_FULL = QCW'(spi_hs_pkg::QUEUE_DEPTH);

  spi_hs_pkg::tick_t mem_q [spi_hs_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]    wr_ptr_q;
  logic [QAW-1:0]    rd_ptr_q;
  logic [QCW-1:0]    cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

[hw/rtl/spi_hs_back.sv]
// spi_hs_back: SPI frame engine, one tick per beat, with config registers and
// the registered result stage. Depends on spi_hs_pkg.
module spi_hs_back #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spi_hs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spi_hs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              tick_valid_i,
  output logic                              tick_ready_o,
  input  spi_hs_pkg::tick_t                 tick_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output spi_hs_pkg::res_t                  res_o
);

  localparam int unsigned CW    = $clog2(DATA_BITS + 2);
  localparam int unsigned EXT_W = (DATA_BITS > spi_hs_pkg::SEND_W) ?
                                  DATA_BITS : spi_hs_pkg::SEND_W;
  localparam int unsigned FBX_W = spi_hs_pkg::FBITS_W + 1;
  localparam logic [FBX_W-1:0] DB_LIM = FBX_W'(DATA_BITS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_LOW,
    PH_HIGH,
    PH_GAP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_RD,
    KIND_WR,
    KIND_RW
  } kind_e;

  logic [spi_hs_pkg::HALF_W-1:0]  half_q;
  logic [spi_hs_pkg::FBITS_W-1:0] fbits_q;
  logic [spi_hs_pkg::MFR_W-1:0]   mfr_q;

  phase_e                         phase_q, phase_d;
  kind_e                          kind_q, kind_d;
  spi_hs_pkg::mode_e              hmode_q, hmode_d;
  logic [CW-1:0]                  bit_q, bit_d;
  logic [spi_hs_pkg::HALF_W-1:0]  tick_q, tick_d;
  logic [spi_hs_pkg::MFR_W-1:0]   fcnt_q, fcnt_d;
  logic [spi_hs_pkg::SEND_W-1:0]  tx_q, tx_d;
  logic [DATA_BITS-1:0]           rx_q, rx_d;
  logic                           valid_q, valid_d;
  logic                           ready_q, ready_d;
  logic                           sent_q, sent_d;
  logic                           hch_q, hch_d;
  logic                           succ_q, succ_d;
  spi_hs_pkg::res_t               res_q, res_d;
  logic                           res_vld_q;

  logic [spi_hs_pkg::HALF_W-1:0]  half;
  logic [FBX_W-1:0]               fb_ext;
  logic [FBX_W-1:0]               nb_ext;
  logic [CW-1:0]                  nbits;
  logic [spi_hs_pkg::MFR_W-1:0]   limit;
  logic [spi_hs_pkg::MFR_W-1:0]   fcnt_inc;
  logic [spi_hs_pkg::HALF_W:0]    tick_inc;
  logic [DATA_BITS-1:0]           mask;
  logic [CW-1:0]                  d_idx;
  logic [CW-1:0]                  t_idx;
  logic [EXT_W-1:0]               tx_ext;
  logic [EXT_W-1:0]               tx_sh;
  logic [EXT_W-1:0]               rx_ext;
  logic                           level;
  logic                           fin;
  logic                           ok;
  logic                           begin_f;
  logic                           done;
  logic                           act;
  logic                           sck;
  logic                           mosi;
  logic                           pop;

  assign half     = (half_q == '0) ? spi_hs_pkg::HALF_W'(1) : half_q;
  assign fb_ext   = {1'b0, fbits_q};
  assign nb_ext   = (fbits_q == '0) ? FBX_W'(1) : ((fb_ext > DB_LIM) ? DB_LIM : fb_ext);
  assign nbits    = CW'(nb_ext);
  assign limit    = (mfr_q == '0) ? spi_hs_pkg::MFR_W'(1) : mfr_q;
  assign fcnt_inc = (fcnt_q == spi_hs_pkg::FRAME_CNT_MAX) ? fcnt_q :
                    fcnt_q + spi_hs_pkg::MFR_W'(1);
  assign tick_inc = {1'b0, tick_q} + (spi_hs_pkg::HALF_W + 1)'(1);
  assign mask     = {DATA_BITS{1'b1}} >> (CW'(DATA_BITS) - nbits);
  assign level    = hch_q ? tick_i.miso_one : tick_i.miso_zero;
  assign fin      = (hmode_q == spi_hs_pkg::MODE_WR) ? ready_q : valid_q;
  assign ok       = (hmode_q == spi_hs_pkg::MODE_RW) ? sent_q : 1'b1;

  assign tick_ready_o = ~res_vld_q | res_ready_i;
  assign pop          = tick_valid_i & tick_ready_o;
  assign res_valid_o  = res_vld_q;
  assign res_o        = res_q;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    hmode_d = hmode_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    fcnt_d  = fcnt_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    valid_d = valid_q;
    ready_d = ready_q;
    sent_d  = sent_q;
    hch_d   = hch_q;
    succ_d  = succ_q;
    begin_f = 1'b0;
    done    = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (tick_i.start) begin
        hmode_d = tick_i.mode;
        hch_d   = tick_i.channel;
        tx_d    = tick_i.send_data;
        valid_d = 1'b0;
        ready_d = 1'b0;
        sent_d  = 1'b0;
        fcnt_d  = '0;
        begin_f = 1'b1;
      end
    end else if (tick_inc >= {1'b0, half}) begin
      tick_d = '0;
      case (phase_q)
        PH_SETUP: begin
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          phase_d = PH_HIGH;
          if (bit_q == '0) begin
            valid_d = level;
          end else if (bit_q == CW'(1)) begin
            ready_d = level;
          end else if (kind_q != KIND_WR) begin
            rx_d = ((rx_q << 1) | DATA_BITS'(level)) & mask;
          end
        end
        PH_HIGH: begin
          if ({1'b0, bit_q} < ({1'b0, nbits} + (CW + 1)'(1))) begin
            bit_d   = bit_q + CW'(1);
            phase_d = PH_LOW;
          end else begin
            fcnt_d = fcnt_inc;
            if (fin || (fcnt_inc >= limit)) begin
              succ_d  = fin & ok;
              phase_d = PH_IDLE;
              bit_d   = '0;
              done    = 1'b1;
            end else begin
              phase_d = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          begin_f = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end else begin
      tick_d = tick_inc[spi_hs_pkg::HALF_W-1:0];
    end

    if (begin_f) begin
      if (hmode_d == spi_hs_pkg::MODE_WR) begin
        kind_d = KIND_WR;
      end else if ((hmode_d == spi_hs_pkg::MODE_RW) && !sent_d && ready_d) begin
        kind_d = KIND_RW;
        sent_d = 1'b1;
      end else begin
        kind_d = KIND_RD;
      end
      phase_d = PH_SETUP;
      bit_d   = '0;
      tick_d  = '0;
    end
  end

  // pins after this tick
  always_comb begin
    act    = (phase_d == PH_SETUP) || (phase_d == PH_LOW) || (phase_d == PH_HIGH);
    sck    = (phase_d == PH_HIGH);
    d_idx  = bit_d - CW'(2);
    t_idx  = nbits - CW'(1) - d_idx;
    tx_ext = EXT_W'(tx_d);
    tx_sh  = tx_ext >> t_idx;
    rx_ext = EXT_W'(rx_d);
    if (bit_d == '0) begin
      mosi = (kind_d != KIND_RD);
    end else if (bit_d == CW'(1)) begin
      mosi = (kind_d != KIND_WR);
    end else if (kind_d == KIND_RD) begin
      mosi = 1'b0;
    end else if (d_idx >= nbits) begin
      mosi = 1'b0;
    end else begin
      mosi = tx_sh[0];
    end

    res_d.sck_zero   = ~hch_d & act & sck;
    res_d.mosi_zero  = ~hch_d & act & mosi;
    res_d.cs_zero_n  = hch_d | ~act;
    res_d.sck_one    = hch_d & act & sck;
    res_d.mosi_one   = hch_d & act & mosi;
    res_d.cs_one_n   = ~hch_d | ~act;
    res_d.busy_res   = (phase_d != PH_IDLE);
    res_d.done_res   = done;
    res_d.success    = succ_d;
    res_d.recv_data  = rx_ext[spi_hs_pkg::RECV_W-1:0];
    res_d.last_valid = valid_d;
    res_d.last_ready = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= spi_hs_pkg::HALF_RST;
      fbits_q   <= spi_hs_pkg::FBITS_RST;
      mfr_q     <= spi_hs_pkg::MFR_RST;
      phase_q   <= PH_IDLE;
      kind_q    <= KIND_RD;
      hmode_q   <= spi_hs_pkg::MODE_RD;
      bit_q     <= '0;
      tick_q    <= '0;
      fcnt_q    <= '0;
      tx_q      <= '0;
      rx_q      <= '0;
      valid_q   <= 1'b0;
      ready_q   <= 1'b0;
      sent_q    <= 1'b0;
      hch_q     <= 1'b0;
      succ_q    <= 1'b0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spi_hs_pkg::CFG_HALF: begin
            half_q <= cfg_data_i[spi_hs_pkg::HALF_W-1:0];
          end
          spi_hs_pkg::CFG_FBITS: begin
            fbits_q <= cfg_data_i[spi_hs_pkg::FBITS_W-1:0];
          end
          spi_hs_pkg::CFG_MFR: begin
            mfr_q <= cfg_data_i[spi_hs_pkg::MFR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pop) begin
        phase_q   <= phase_d;
        kind_q    <= kind_d;
        hmode_q   <= hmode_d;
        bit_q     <= bit_d;
        tick_q    <= tick_d;
        fcnt_q    <= fcnt_d;
        tx_q      <= tx_d;
        rx_q      <= rx_d;
        valid_q   <= valid_d;
        ready_q   <= ready_d;
        sent_q    <= sent_d;
        hch_q     <= hch_d;
        succ_q    <= succ_d;
        res_q     <= res_d;
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/spi_master_handshake_transfer.sv]
// spi_master_handshake_transfer: top level of the two-channel SPI master with
// valid/ready header. Depends on spi_hs_pkg, spi_hs_front, spi_hs_queue, spi_hs_back.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+------------------------------------
//   tick    | in  | in_valid_i / in_ready_o | start_req, mode, channel, send_data,
//           |     |                         | miso_zero, miso_one
//   result  | out | out_valid_o/out_ready_i | pins, busy, done, success, recv_data,
//           |     |                         | last_valid, last_ready
//   config  | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One tick beat in, one result beat out; one per cycle unless out_ready_i stalls.
// A beat passes the front register, the queue and the engine result register.
// The engine does the whole tick update combinationally; the 2-entry queue lets the
// front keep accepting while the result side stalls, until the queue is full.
// Reset clears all but the queue memory; registers return to 10 / 32 / 500.
module spi_master_handshake_transfer #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spi_hs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spi_hs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_req_i,
  input  logic [1:0]                        mode_i,
  input  logic                              channel_i,
  input  logic [spi_hs_pkg::SEND_W-1:0]     send_data_i,
  input  logic                              miso_zero_i,
  input  logic                              miso_one_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              sck_zero_o,
  output logic                              mosi_zero_o,
  output logic                              cs_zero_n_o,
  output logic                              sck_one_o,
  output logic                              mosi_one_o,
  output logic                              cs_one_n_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic                              success_o,
  output logic [spi_hs_pkg::RECV_W-1:0]     recv_data_o,
  output logic                              last_valid_o,
  output logic                              last_ready_o
);

  logic              push_valid;
  logic              push_ready;
  spi_hs_pkg::tick_t push_item;
  logic              pop_valid;
  logic              pop_ready;
  spi_hs_pkg::tick_t pop_item;
  spi_hs_pkg::res_t  res;

  spi_hs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .mode_i       (mode_i),
    .channel_i    (channel_i),
    .send_data_i  (send_data_i),
    .miso_zero_i  (miso_zero_i),
    .miso_one_i   (miso_one_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push_item)
  );

  spi_hs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_item)
  );

  spi_hs_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (pop_valid),
    .tick_ready_o (pop_ready),
    .tick_i       (pop_item),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign sck_zero_o   = res.sck_zero;
  assign mosi_zero_o  = res.mosi_zero;
  assign cs_zero_n_o  = res.cs_zero_n;
  assign sck_one_o    = res.sck_one;
  assign mosi_one_o   = res.mosi_one;
  assign cs_one_n_o   = res.cs_one_n;
  assign busy_res_o   = res.busy_res;
  assign done_res_o   = res.done_res;
  assign success_o    = res.success;
  assign recv_data_o  = res.recv_data;
  assign last_valid_o = res.last_valid;
  assign last_ready_o = res.last_ready;

`ifndef SYNTHESIS
  a_one_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cs_zero_n_o || cs_one_n_o))
    else $error("both chip selects active");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("done beat while still busy");

  a_cs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!cs_zero_n_o || !cs_one_n_o)) |-> busy_res_o)
    else $error("chip select active while idle");

  a_sck_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sck_zero_o || mosi_zero_o)) |-> !cs_zero_n_o)
    else $error("channel 0 pins toggle with chip select high");
`endif

endmodule

[tb/sv/tb.sv]
// Testbench for spi_master_handshake_transfer: per-tick prediction of pins and status,
// compared beat by beat against the result channel under random idling and back-pressure.
// Depends on spi_hs_pkg and the RTL of spi_master_handshake_transfer.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned LATENCY     = 3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_LONG   = 80;

  localparam logic [1:0]                       MODE_UNDEF = 2'd3;
  localparam logic [spi_hs_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  typedef enum logic [2:0] {PH_IDLE, PH_SETUP, PH_LOW, PH_HIGH, PH_GAP} phase_e;
  typedef enum logic [1:0] {KIND_RD, KIND_WR, KIND_RW} kind_e;
  typedef enum logic [1:0] {MISO_RANDOM, MISO_LOW, MISO_HIGH} miso_style_e;

  typedef struct packed {
    logic        start;
    logic [1:0]  mode;
    logic        channel;
    logic [31:0] data;
    logic        miso_zero;
    logic        miso_one;
  } stim_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [spi_hs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [spi_hs_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              start_req_i;
  logic [1:0]                        mode_i;
  logic                              channel_i;
  logic [spi_hs_pkg::SEND_W-1:0]     send_data_i;
  logic                              miso_zero_i;
  logic                              miso_one_i;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              sck_zero_o, mosi_zero_o, cs_zero_n_o;
  logic                              sck_one_o, mosi_one_o, cs_one_n_o;
  logic                              busy_res_o, done_res_o, success_o;
  logic [spi_hs_pkg::RECV_W-1:0]     recv_data_o;
  logic                              last_valid_o, last_ready_o;

  spi_master_handshake_transfer #(.DATA_BITS(DATA_BITS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .mode_i       (mode_i),
    .channel_i    (channel_i),
    .send_data_i  (send_data_i),
    .miso_zero_i  (miso_zero_i),
    .miso_one_i   (miso_one_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sck_zero_o   (sck_zero_o),
    .mosi_zero_o  (mosi_zero_o),
    .cs_zero_n_o  (cs_zero_n_o),
    .sck_one_o    (sck_one_o),
    .mosi_one_o   (mosi_one_o),
    .cs_one_n_o   (cs_one_n_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .success_o    (success_o),
    .recv_data_o  (recv_data_o),
    .last_valid_o (last_valid_o),
    .last_ready_o (last_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted engine state
  logic [spi_hs_pkg::HALF_W-1:0]  m_half;
  logic [spi_hs_pkg::FBITS_W-1:0] m_fbits;
  logic [spi_hs_pkg::MFR_W-1:0]   m_mfr;
  phase_e                         m_phase;
  kind_e                          m_kind;
  int unsigned                    m_bit, m_tick, m_frames;
  logic [31:0]                    m_tx, m_rx;
  logic                           m_valid, m_ready, m_sent, m_chan, m_success;
  logic [1:0]                     m_mode;

  spi_hs_pkg::res_t tick_result_q[$];
  int unsigned      err_cnt = 0;
  int unsigned      stall_cycles = 0;
  int unsigned      rx_hold_len = 0;
  int unsigned      rx_gap;
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;

  function automatic void reset_model();
    m_half = spi_hs_pkg::HALF_RST;
    m_fbits = spi_hs_pkg::FBITS_RST;
    m_mfr = spi_hs_pkg::MFR_RST;
    m_phase = PH_IDLE;
    m_kind = KIND_RD;
    m_bit = 0;
    m_tick = 0;
    m_frames = 0;
    m_tx = '0;
    m_rx = '0;
    m_valid = 1'b0;
    m_ready = 1'b0;
    m_sent = 1'b0;
    m_chan = 1'b0;
    m_success = 1'b0;
    m_mode = spi_hs_pkg::MODE_RD;
  endfunction

  function automatic int unsigned data_len();
    int unsigned n;
    n = m_fbits;
    if (n == 0) n = 1;
    if (n > DATA_BITS) n = DATA_BITS;
    return n;
  endfunction

  function automatic void open_frame();
    if (m_mode == spi_hs_pkg::MODE_WR) begin
      m_kind = KIND_WR;
    end else if (m_mode == spi_hs_pkg::MODE_RW && !m_sent && m_ready) begin
      m_kind = KIND_RW;
      m_sent = 1'b1;
    end else begin
      m_kind = KIND_RD;
    end
    m_phase = PH_SETUP;
    m_bit = 0;
    m_tick = 0;
  endfunction

  function automatic logic mosi_level();
    int unsigned n, d;
    n = data_len();
    if (m_bit == 0) return m_kind != KIND_RD;
    if (m_bit == 1) return m_kind != KIND_WR;
    if (m_kind == KIND_RD) return 1'b0;
    d = m_bit - 2;
    if (d >= n) return 1'b0;
    return m_tx[n-1-d];
  endfunction

  function automatic void take_miso(logic lv);
    if (m_bit == 0) begin
      m_valid = lv;
    end else if (m_bit == 1) begin
      m_ready = lv;
    end else if (m_kind != KIND_WR) begin
      m_rx = {m_rx[30:0], lv} & (32'hFFFF_FFFF >> (32 - data_len()));
    end
  endfunction

  function automatic logic close_frame();
    int unsigned limit;
    logic fin, ok;
    limit = (m_mfr == 0) ? 1 : m_mfr;
    ok = 1'b1;
    if (m_frames < spi_hs_pkg::FRAME_CNT_MAX) m_frames++;
    if (m_mode == spi_hs_pkg::MODE_WR) begin
      fin = m_ready;
    end else begin
      fin = m_valid;
      if (m_mode == spi_hs_pkg::MODE_RW) ok = m_sent;
    end
    if (fin || m_frames >= limit) begin
      m_success = fin && ok;
      m_phase = PH_IDLE;
      m_tick = 0;
      m_bit = 0;
      return 1'b1;
    end
    m_phase = PH_GAP;
    m_tick = 0;
    return 1'b0;
  endfunction

  // one timer tick of the SPI engine; pushes the pin/status word it produces
  function automatic void step_spi_master(stim_t t);
    spi_hs_pkg::res_t r;
    int unsigned      half;
    logic             lv, sck, mosi, csn, done;
    half = (m_half == 0) ? 1 : m_half;
    lv = m_chan ? t.miso_one : t.miso_zero;
    sck = 1'b0;
    mosi = 1'b0;
    csn = 1'b1;
    done = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (t.start) begin
        m_mode = (t.mode == MODE_UNDEF) ? spi_hs_pkg::MODE_RD : t.mode;
        m_chan = t.channel;
        m_tx = t.data;
        m_valid = 1'b0;
        m_ready = 1'b0;
        m_sent = 1'b0;
        m_frames = 0;
        open_frame();
      end
    end else begin
      m_tick++;
      if (m_tick >= half) begin
        m_tick = 0;
        case (m_phase)
          PH_SETUP: m_phase = PH_LOW;
          PH_LOW: begin
            m_phase = PH_HIGH;
            take_miso(lv);
          end
          PH_HIGH: begin
            if (m_bit + 1 < data_len() + 2) begin
              m_bit++;
              m_phase = PH_LOW;
            end else begin
              done = close_frame();
            end
          end
          default: open_frame();
        endcase
      end
    end
    if (m_phase == PH_SETUP || m_phase == PH_LOW || m_phase == PH_HIGH) begin
      csn = 1'b0;
      mosi = mosi_level();
      sck = (m_phase == PH_HIGH);
    end
    r.sck_zero = m_chan ? 1'b0 : sck;
    r.mosi_zero = m_chan ? 1'b0 : mosi;
    r.cs_zero_n = m_chan ? 1'b1 : csn;
    r.sck_one = m_chan ? sck : 1'b0;
    r.mosi_one = m_chan ? mosi : 1'b0;
    r.cs_one_n = m_chan ? csn : 1'b1;
    r.busy_res = (m_phase != PH_IDLE);
    r.done_res = done;
    r.success = m_success;
    r.recv_data = m_rx;
    r.last_valid = m_valid;
    r.last_ready = m_ready;
    tick_result_q.push_back(r);
  endfunction

  function automatic stim_t make_tick(logic start, logic [1:0] mode, logic chan,
                                      logic [31:0] data, logic m0, logic m1);
    stim_t t;
    t.start = start;
    t.mode = mode;
    t.channel = chan;
    t.data = data;
    t.miso_zero = m0;
    t.miso_one = m1;
    return t;
  endfunction

  function automatic stim_t start_tick();
    return make_tick(1'b1, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // tick during a request: mostly no start, held channel follows the MISO style
  function automatic stim_t busy_tick(miso_style_e style);
    logic lv, other;
    lv = (style == MISO_LOW) ? 1'b0 :
         (style == MISO_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
    other = 1'($urandom_range(0, 1));
    return make_tick($urandom_range(0, 4) == 0, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), $urandom(),
                     m_chan ? other : lv, m_chan ? lv : other);
  endfunction

  task automatic send_tick(stim_t t);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_req_i = t.start;
    mode_i = t.mode;
    channel_i = t.channel;
    send_data_i = t.data;
    miso_zero_i = t.miso_zero;
    miso_one_i = t.miso_one;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    step_spi_master(t);
  endtask

  // sender pauses until every predicted beat has come back
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tick_result_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [spi_hs_pkg::CFG_IDX_W-1:0] idx,
                           logic [spi_hs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      spi_hs_pkg::CFG_HALF:  m_half = val;
      spi_hs_pkg::CFG_FBITS: m_fbits = val[spi_hs_pkg::FBITS_W-1:0];
      spi_hs_pkg::CFG_MFR:   m_mfr = val[spi_hs_pkg::MFR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [spi_hs_pkg::CFG_DATA_W-1:0] half,
                            logic [spi_hs_pkg::CFG_DATA_W-1:0] fbits,
                            logic [spi_hs_pkg::CFG_DATA_W-1:0] mfr);
    quiesce();
    write_reg(spi_hs_pkg::CFG_HALF, half);
    write_reg(spi_hs_pkg::CFG_FBITS, fbits);
    write_reg(spi_hs_pkg::CFG_MFR, mfr);
  endtask

  task automatic finish_request(miso_style_e style);
    while (m_phase != PH_IDLE) send_tick(busy_tick(style));
  endtask

  task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_tick_result();
    spi_hs_pkg::res_t want;
    if (tick_result_q.size() == 0) begin
      $error("result beat with no prediction pending");
      err_cnt++;
      return;
    end
    want = tick_result_q.pop_front();
    match_field("sck_zero", want.sck_zero, sck_zero_o);
    match_field("mosi_zero", want.mosi_zero, mosi_zero_o);
    match_field("cs_zero_n", want.cs_zero_n, cs_zero_n_o);
    match_field("sck_one", want.sck_one, sck_one_o);
    match_field("mosi_one", want.mosi_one, mosi_one_o);
    match_field("cs_one_n", want.cs_one_n, cs_one_n_o);
    match_field("busy_res", want.busy_res, busy_res_o);
    match_field("done_res", want.done_res, done_res_o);
    match_field("success", want.success, success_o);
    match_field("recv_data", want.recv_data, recv_data_o);
    match_field("last_valid", want.last_valid, last_valid_o);
    match_field("last_ready", want.last_ready, last_ready_o);
  endtask

  // result side
  initial begin
    forever begin
      if (rx_hold_len > 0) begin
        rx_gap = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        rx_gap = rx_idle_en ? $urandom_range(0, 9) : 0;
      end
      @(negedge clk_i);
      if (rx_gap > 0) begin
        out_ready_i = 1'b0;
        repeat (rx_gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_tick_result();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_idle_after_reset();
    send_tick(make_tick(1'b0, MODE_UNDEF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_tick(make_tick(1'b0, spi_hs_pkg::MODE_RD, 1'b0, 32'h0000_0000, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, spi_hs_pkg::MODE_RW, 1'b1, 32'hAAAA_5555, 1'b1, 1'b0));
  endtask

  // every mode once at the smallest settings; starts while busy are ignored
  task automatic test_each_mode();
    set_config(16'd1, 16'd1, 16'd1);
    send_tick(make_tick(1'b1, spi_hs_pkg::MODE_RD, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1));
    finish_request(MISO_HIGH);
    send_tick(make_tick(1'b1, spi_hs_pkg::MODE_WR, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    finish_request(MISO_HIGH);
    send_tick(make_tick(1'b1, spi_hs_pkg::MODE_RW, 1'b0, 32'h8000_0001, 1'b1, 1'b1));
    finish_request(MISO_HIGH);
    send_tick(make_tick(1'b1, MODE_UNDEF, 1'b1, 32'h0000_0000, 1'b0, 1'b0));
    finish_request(MISO_RANDOM);
  endtask

  // registers rewritten while a request is open, the pipeline drained
  task automatic test_config_mid_request();
    set_config(16'hFFFF, 16'd63, 16'hFFFF);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_tick(make_tick(1'b1, spi_hs_pkg::MODE_RW, 1'b1, 32'hDEAD_BEEF, 1'b1, 1'b1));
    repeat (3) send_tick(busy_tick(MISO_HIGH));
    quiesce();
    write_reg(spi_hs_pkg::CFG_HALF, 16'd1);
    repeat (12) send_tick(busy_tick(MISO_HIGH));
    quiesce();
    write_reg(spi_hs_pkg::CFG_FBITS, 16'h0041);
    write_reg(spi_hs_pkg::CFG_MFR, 16'd1);
    finish_request(MISO_HIGH);
  endtask

  task automatic run_traffic(int unsigned budget);
    int unsigned sent;
    miso_style_e style;
    int unsigned pick;
    sent = 0;
    style = MISO_RANDOM;
    while (sent < budget) begin
      if (m_phase == PH_IDLE) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(busy_tick(MISO_RANDOM) & ~{1'b1, 37'd0});
        end else begin
          pick = $urandom_range(0, 9);
          style = (m_mfr > 8 || m_mfr == 0) ? MISO_RANDOM :
                  (pick < 2) ? MISO_LOW : (pick < 4) ? MISO_HIGH : MISO_RANDOM;
          send_tick(start_tick());
        end
      end else begin
        send_tick(busy_tick(style));
      end
      sent++;
    end
    finish_request(style);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(16'd0, 16'd0, 16'd0);
        1: set_config(16'd1, 16'd32, 16'd2);
        2: set_config(16'd2, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)));
        3: set_config(16'd1, 16'd63, 16'd1);
        4: set_config(16'($urandom_range(0, 3)), 16'($urandom_range(2, 12)),
                      16'($urandom_range(2, 5)));
        5: set_config(16'd1, 16'($urandom_range(1, 4)), 16'hFFFF);
        6: set_config(16'($urandom_range(1, 2)), 16'($urandom_range(1, 8)),
                      16'($urandom_range(1, 8)));
        default: set_config(16'd3, 16'd5, 16'd3);
      endcase
      tx_idle_en = (p % 3 != 2);
      rx_idle_en = (p % 3 != 2);
      run_traffic(120);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off while the sender streams, filling the block
  task automatic test_backpressure();
    set_config(16'd1, 16'd4, 16'd3);
    tx_idle_en = 1'b0;
    rx_hold_len = HOLD_LONG;
    run_traffic(40);
    tx_idle_en = 1'b1;
    quiesce();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = spi_hs_pkg::CFG_HALF;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_req_i = 1'b0;
    mode_i = spi_hs_pkg::MODE_RD;
    channel_i = 1'b0;
    send_data_i = '0;
    miso_zero_i = 1'b0;
    miso_one_i = 1'b0;
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_after_reset();
    test_each_mode();
    test_config_mid_request();
    test_random_settings();
    test_backpressure();

    quiesce();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
